[rtl/vts_pkg.sv]
// Shared widths, payload types and register codes for the vertex transform pipeline.
package vts_pkg;

	// Fixed-point formats.
	localparam int POS_W  = 32;              // Q16.16 input and result width
	localparam int COEF_W = 16;              // Q8.8 matrix coefficient width
	localparam int FRAC_W = 16;              // fraction bits of a Q16.16 value
	localparam int PROD_W = POS_W + COEF_W;  // one coefficient times one coordinate
	localparam int ACC_W  = 51;              // signed Q24.24 row sum with headroom
	localparam int QUO_W  = 31;              // unsigned quotient magnitude below 2^31
	localparam int NLO_W  = QUO_W - FRAC_W;  // numerator bits fed into the divider
	localparam int UX_W   = FRAC_W + 1;      // coordinate plus one, visible range
	localparam int RES_W  = 13;              // resolution register width
	localparam int PIX_W  = 12;              // pixel coordinate width
	localparam int CFG_W  = 64;              // configuration data width

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [ACC_W-1:0]        mag_t;

	// One lane of the restoring divider as it moves down the pipeline.
	typedef struct packed {
		mag_t             rem;
		logic [NLO_W-1:0] num_lo;
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             sat;
	} dlane_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_ROW0   = 3'd0,
		CFG_ROW1   = 3'd1,
		CFG_ROW2   = 3'd2,
		CFG_ROW3   = 3'd3,
		CFG_WIDTH  = 3'd4,
		CFG_HEIGHT = 3'd5
	} cfg_idx_t;

	localparam logic [RES_W-1:0] WIDTH_RST  = RES_W'(640);
	localparam logic [RES_W-1:0] HEIGHT_RST = RES_W'(480);
	localparam logic signed [POS_W-1:0] SAT_POS = 32'sh7FFF_FFFF;
	localparam logic signed [POS_W-1:0] SAT_NEG = 32'sh8000_0000;
	localparam logic [UX_W-1:0] ONE_Q = UX_W'(1) << FRAC_W;

endpackage

[rtl/vertex_transform_to_screen.sv]
// Vertex transform: 4x4 matrix multiply, divide by w, saturation and viewport mapping.
// Throughput: one vertex per cycle unless the output stalls; every stage is a register
// and the divider resolves one quotient bit per stage in three parallel lanes (31 stages).
// A stalled output holds; stages ahead of it keep filling bubbles until full.
// Reset clears all valid bits, the matrix to zero and the resolution to 640 by 480.
module vertex_transform_to_screen
	import vts_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [2:0]               cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [POS_W-1:0]  out_x,
	output logic signed [POS_W-1:0]  out_y,
	output logic signed [POS_W-1:0]  out_z,
	output logic [PIX_W-1:0]         pixel_x,
	output logic [PIX_W-1:0]         pixel_y,
	output logic                     visible,
	output logic                     w_zero
);

	localparam int N_DIV = QUO_W;

	// Configuration registers.
	logic [CFG_W-1:0] matrix_q [4];
	logic [RES_W-1:0] width_q;
	logic [RES_W-1:0] height_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 4; r++) matrix_q[r] <= '0;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ROW0:   matrix_q[0] <= cfg_data;
				CFG_ROW1:   matrix_q[1] <= cfg_data;
				CFG_ROW2:   matrix_q[2] <= cfg_data;
				CFG_ROW3:   matrix_q[3] <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data[RES_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[RES_W-1:0];
				default: ;
			endcase
		end
	end

	// Coefficient unpacking and input vector.
	logic signed [COEF_W-1:0] coef [4][4];
	logic signed [POS_W-1:0]  pos  [3];

	always_comb begin
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++)
				coef[r][c] = matrix_q[r][COEF_W*c +: COEF_W];
		pos[0] = pos_x;
		pos[1] = pos_y;
		pos[2] = pos_z;
	end

	// Valid bits and stage enables; a stage loads when it is empty or its successor moves.
	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s6, vld_s7;
	logic [N_DIV-1:0] vld_s5;
	logic             en_s1, en_s2, en_s3, en_s4, en_s6, en_s7;
	logic [N_DIV-1:0] en_s5;

	always_comb begin
		en_s7 = !vld_s7 || !out_stall;
		en_s6 = !vld_s6 || en_s7;
		en_s5[N_DIV-1] = !vld_s5[N_DIV-1] || en_s6;
		for (int k = N_DIV-2; k >= 0; k--)
			en_s5[k] = !vld_s5[k] || en_s5[k+1];
		en_s4 = !vld_s4 || en_s5[0];
		en_s3 = !vld_s3 || en_s4;
		en_s2 = !vld_s2 || en_s3;
		en_s1 = !vld_s1 || en_s2;
	end

	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= '0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5[0]) vld_s5[0] <= vld_s4;
			for (int k = 1; k < N_DIV; k++)
				if (en_s5[k]) vld_s5[k] <= vld_s5[k-1];
			if (en_s6) vld_s6 <= vld_s5[N_DIV-1];
			if (en_s7) vld_s7 <= vld_s6;
		end
	end

	// Stage 1: twelve coefficient-by-coordinate products.
	logic signed [PROD_W-1:0] prod_s1 [4][3];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int r = 0; r < 4; r++)
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= coef[r][c] * pos[c];
		end
	end

	// Stage 2: row sums in Q24.24; the constant one of the vector scales column three.
	acc_t acc_s2 [4];
	acc_t acc_nx [4];

	always_comb begin
		for (int r = 0; r < 4; r++)
			acc_nx[r] = acc_t'(prod_s1[r][0]) + acc_t'(prod_s1[r][1])
				+ acc_t'(prod_s1[r][2]) + (acc_t'(coef[r][3]) <<< FRAC_W);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int r = 0; r < 4; r++) acc_s2[r] <= acc_nx[r];
		end
	end

	// Stage 3: magnitudes, quotient signs and the zero-w flag.
	mag_t un_s3 [3];
	logic neg_s3 [3];
	mag_t uw_s3;
	logic wz_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int l = 0; l < 3; l++) begin
				un_s3[l]  <= acc_s2[l][ACC_W-1] ? mag_t'(-acc_s2[l]) : mag_t'(acc_s2[l]);
				neg_s3[l] <= acc_s2[l][ACC_W-1] ^ acc_s2[3][ACC_W-1];
			end
			uw_s3 <= acc_s2[3][ACC_W-1] ? mag_t'(-acc_s2[3]) : mag_t'(acc_s2[3]);
			wz_s3 <= (acc_s2[3] == '0);
		end
	end

	// Stage 4: overflow test (integer part of the quotient 2^15 or more) and divider setup.
	dlane_t dl_s4 [3];
	mag_t   uw_s4;
	logic   wz_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int l = 0; l < 3; l++) begin
				dl_s4[l].rem    <= un_s3[l] >> NLO_W;
				dl_s4[l].num_lo <= un_s3[l][NLO_W-1:0];
				dl_s4[l].quo    <= '0;
				dl_s4[l].neg    <= neg_s3[l];
				dl_s4[l].sat    <= wz_s3
					|| ({NLO_W'(0), un_s3[l]} >= {uw_s3, NLO_W'(0)});
			end
			uw_s4 <= uw_s3;
			wz_s4 <= wz_s3;
		end
	end

	// Stage 5: restoring divider, one quotient bit per stage, most significant first.
	dlane_t dl_s5 [N_DIV][3];
	mag_t   uw_s5 [N_DIV];
	logic   wz_s5 [N_DIV];

	for (genvar k = 0; k < N_DIV; k++) begin : g_div
		localparam int BIT = N_DIV - 1 - k;
		localparam int NB_IDX = (BIT >= FRAC_W) ? BIT - FRAC_W : 0;
		dlane_t src [3];
		dlane_t nxt [3];
		mag_t   uw_src;
		logic   wz_src;
		logic [ACC_W:0] trial [3];
		logic nb [3];

		if (k == 0) begin : g_first
			assign src    = dl_s4;
			assign uw_src = uw_s4;
			assign wz_src = wz_s4;
		end else begin : g_next
			assign src    = dl_s5[k-1];
			assign uw_src = uw_s5[k-1];
			assign wz_src = wz_s5[k-1];
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (BIT >= FRAC_W) nb[l] = src[l].num_lo[NB_IDX];
				else nb[l] = 1'b0;
				trial[l] = {src[l].rem, nb[l]};
				nxt[l]   = src[l];
				if (trial[l] >= {1'b0, uw_src}) begin
					nxt[l].rem      = ACC_W'(trial[l] - {1'b0, uw_src});
					nxt[l].quo[BIT] = 1'b1;
				end else begin
					nxt[l].rem = trial[l][ACC_W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en_s5[k]) begin
				dl_s5[k] <= nxt;
				uw_s5[k] <= uw_src;
				wz_s5[k] <= wz_src;
			end
		end
	end

	// Stage 6: signed, saturated quotients, visibility and coordinate plus one.
	logic signed [POS_W-1:0] res_s6 [3];
	logic                    vis_s6;
	logic                    wz_s6;
	logic [UX_W-1:0]         ux_s6 [2];
	dlane_t                  fin [3];
	logic                    unit_mag [2];

	always_comb begin
		fin = dl_s5[N_DIV-1];
		for (int l = 0; l < 2; l++)
			unit_mag[l] = !fin[l].sat && (fin[l].quo[QUO_W-1:FRAC_W] == '0);
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			for (int l = 0; l < 3; l++) begin
				if (fin[l].sat) res_s6[l] <= fin[l].neg ? SAT_NEG : SAT_POS;
				else if (fin[l].neg) res_s6[l] <= -$signed({1'b0, fin[l].quo});
				else res_s6[l] <= $signed({1'b0, fin[l].quo});
			end
			for (int l = 0; l < 2; l++)
				ux_s6[l] <= fin[l].neg ? ONE_Q - fin[l].quo[UX_W-1:0]
					: ONE_Q + fin[l].quo[UX_W-1:0];
			vis_s6 <= unit_mag[0] && unit_mag[1];
			wz_s6  <= wz_s5[N_DIV-1];
		end
	end

	// Stage 7: viewport scaling into pixels, saturated; this is the output register.
	logic signed [POS_W-1:0]  res_s7 [3];
	logic [PIX_W-1:0]         pix_s7 [2];
	logic                     vis_s7;
	logic                     wz_s7;
	logic [UX_W+RES_W-1:0]    pprod [2];
	logic [RES_W-1:0]         pfull [2];
	logic [RES_W-1:0]         res_sel [2];

	always_comb begin
		res_sel[0] = width_q;
		res_sel[1] = height_q;
		for (int l = 0; l < 2; l++) begin
			pprod[l] = ux_s6[l] * res_sel[l];
			pfull[l] = pprod[l][UX_W+RES_W-1:UX_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			res_s7 <= res_s6;
			for (int l = 0; l < 2; l++) begin
				if (!vis_s6) pix_s7[l] <= '0;
				else if (pfull[l][RES_W-1]) pix_s7[l] <= '1;
				else pix_s7[l] <= pfull[l][PIX_W-1:0];
			end
			vis_s7 <= vis_s6;
			wz_s7  <= wz_s6;
		end
	end

	assign out_valid = vld_s7;
	assign out_x     = res_s7[0];
	assign out_y     = res_s7[1];
	assign out_z     = res_s7[2];
	assign pixel_x   = pix_s7[0];
	assign pixel_y   = pix_s7[1];
	assign visible   = vis_s7;
	assign w_zero    = wz_s7;

	// A zero w saturates every quotient, so the vertex can never be on screen.
	a_wz_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && w_zero |-> !visible)
		else $error("w_zero result marked visible");

	// Off-screen results carry zero pixel coordinates.
	a_hidden_pix: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !visible |-> pixel_x == '0 && pixel_y == '0)
		else $error("off-screen result with nonzero pixel");

	// The input is only held off when the first stage is occupied and cannot move.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && !en_s2)
		else $error("input stalled with room in the pipeline");

	// An input transfer always lands in the first stage.
	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1)
		else $error("input transfer lost at the first stage");

endmodule

[tb/tb_vertex_transform_to_screen.sv]
// Self-checking testbench for the vertex transform to screen coordinates pipeline.
`timescale 1ns / 100ps

module tb_vertex_transform_to_screen;
	import vts_pkg::*;

	localparam int LIMIT = 400000;
	localparam int DRAIN = 60;
	localparam int HOLD = 300;
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam logic [63:0] IDENT_ROW0 = 64'h0000_0000_0000_0100;
	localparam logic [63:0] IDENT_ROW1 = 64'h0000_0000_0100_0000;
	localparam logic [63:0] IDENT_ROW2 = 64'h0000_0100_0000_0000;
	localparam logic [63:0] IDENT_ROW3 = 64'h0100_0000_0000_0000;

	// One expected result of the block.
	typedef struct {
		logic signed [31:0] ox, oy, oz;
		logic [11:0]        px, py;
		logic               vis, wz;
	} screen_vtx_t;

	// Vertex predictor and the queue of results it has worked out.
	class vertex_board;
		logic [63:0]  rows [4];
		logic [12:0]  width, height;
		screen_vtx_t  pending [$];
		int           errors;

		function new();
			rows = '{default: '0};
			width = 13'd640;
			height = 13'd480;
			errors = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] data);
			if (idx <= CFG_ROW3)
				rows[idx[1:0]] = data;
			else if (idx == CFG_WIDTH)
				width = data[12:0];
			else if (idx == CFG_HEIGHT)
				height = data[12:0];
		endfunction

		function longint coef_at(int r, int c);
			return longint'($signed(rows[r][16*c +: 16]));
		endfunction

		// Signed Q24.24 divided into Q16.16, truncated toward zero and saturated.
		function longint divide_q(longint n, longint w);
			bit neg;
			longint unsigned un, uw, a, r, m;
			if (w == 0)
				return (n < 0) ? -64'sd2147483648 : 64'sd2147483647;
			neg = (n < 0) != (w < 0);
			un = (n < 0) ? longint'(-n) : n;
			uw = (w < 0) ? longint'(-w) : w;
			a = un / uw;
			r = un % uw;
			if (a >= 32768)
				return neg ? -64'sd2147483648 : 64'sd2147483647;
			m = a;
			for (int i = 0; i < 16; i++) begin
				r = r << 1;
				m = m << 1;
				if (r >= uw) begin
					r = r - uw;
					m = m | 1;
				end
			end
			return neg ? -longint'(m) : longint'(m);
		endfunction

		function logic [11:0] to_pixel(longint q, logic [12:0] res);
			longint unsigned p;
			p = (longint'(q + 65536) * longint'(res)) >> 17;
			return (p > 4095) ? 12'd4095 : p[11:0];
		endfunction

		// Transforms one accepted vertex and queues the result.
		function void note(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
			longint v [4];
			longint acc [4];
			longint q [3];
			screen_vtx_t e;
			v[0] = x;
			v[1] = y;
			v[2] = z;
			v[3] = 65536;
			for (int r = 0; r < 4; r++) begin
				acc[r] = 0;
				for (int c = 0; c < 4; c++)
					acc[r] += coef_at(r, c) * v[c];
			end
			for (int r = 0; r < 3; r++)
				q[r] = divide_q(acc[r], acc[3]);
			e.vis = q[0] > -65536 && q[0] < 65536 && q[1] > -65536 && q[1] < 65536;
			e.ox = q[0][31:0];
			e.oy = q[1][31:0];
			e.oz = q[2][31:0];
			e.px = e.vis ? to_pixel(q[0], width) : 12'd0;
			e.py = e.vis ? to_pixel(q[1], height) : 12'd0;
			e.wz = (acc[3] == 0);
			pending.insert(pending.size(), e);
		endfunction

		function void report(string what, longint got, longint want);
			errors++;
			$display("mismatch %s: got %0h expected %0h", what, got, want);
		endfunction

		// Compares one result transfer with the oldest expectation.
		function void check(screen_vtx_t g);
			screen_vtx_t e;
			if (pending.size() == 0) begin
				report("unexpected result", 1, 0);
				return;
			end
			e = pending.pop_front();
			if (g.ox !== e.ox) report("out_x", g.ox, e.ox);
			if (g.oy !== e.oy) report("out_y", g.oy, e.oy);
			if (g.oz !== e.oz) report("out_z", g.oz, e.oz);
			if (g.px !== e.px) report("pixel_x", g.px, e.px);
			if (g.py !== e.py) report("pixel_y", g.py, e.py);
			if (g.vis !== e.vis) report("visible", g.vis, e.vis);
			if (g.wz !== e.wz) report("w_zero", g.wz, e.wz);
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
	logic out_valid, out_stall;
	logic signed [POS_W-1:0] out_x, out_y, out_z;
	logic [PIX_W-1:0] pixel_x, pixel_y;
	logic visible, w_zero;

	vertex_board board;
	int cycles = 0;
	bit calm;
	bit hold_req;

	vertex_transform_to_screen u_top (.*);

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Every result transfer is checked at the edge that moves it.
	always @(posedge clk) begin
		screen_vtx_t g;
		if (arst_n && out_valid && !out_stall) begin
			g.ox = out_x;
			g.oy = out_y;
			g.oz = out_z;
			g.px = pixel_x;
			g.py = pixel_y;
			g.vis = visible;
			g.wz = w_zero;
			board.check(g);
		end
	end

	// Receiver: random stall after each transfer, and one long hold on request.
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			do @(posedge clk); while (!out_valid);
			gap = calm ? 0 : $urandom_range(0, 3);
			if (hold_req && !held) begin
				gap = HOLD;
				held = 1'b1;
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		int gap;
		in_valid <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		do @(posedge clk); while (in_stall);
		board.note(x, y, z);
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every expected result has come and the pipeline is empty.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// Coordinate drawn from a mix of small, near unit and full range values.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
			2: return $urandom_range(0, 1) ? 32'h0001_0000 - $urandom_range(0, 3)
				: 32'hFFFF_0000 + $urandom_range(0, 3);
			default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		endcase
	endfunction

	// Coefficient: mostly modest values, sometimes any 16-bit pattern.
	function automatic logic [15:0] rand_coef();
		if ($urandom_range(0, 3) == 0)
			return 16'($urandom());
		return 16'($signed($urandom_range(0, 1024)) - 512);
	endfunction

	function automatic logic [63:0] rand_row();
		return {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
	endfunction

	// Resolution: extremes or a random value from 1 to 4096.
	function automatic logic [63:0] rand_res();
		case ($urandom_range(0, 5))
			0: return 64'd1;
			1: return 64'd4096;
			2: return 64'd8191;
			3: return 64'd0;
			default: return 64'($urandom_range(1, 4096));
		endcase
	endfunction

	// Main sequence.
	initial begin
		logic [63:0] w_row;
		board = new();
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_ROW0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset matrix is all zero, so w is zero and every result saturates.
		send_vertex(32'h0, 32'h0, 32'h0);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
		drain();

		// Identity transform: extremes, unit edges and points just inside the screen.
		cfg_write(CFG_ROW0, IDENT_ROW0);
		cfg_write(CFG_ROW1, IDENT_ROW1);
		cfg_write(CFG_ROW2, IDENT_ROW2);
		cfg_write(CFG_ROW3, IDENT_ROW3);
		cfg_write(CFG_WIDTH, 64'd4096);
		cfg_write(CFG_HEIGHT, 64'd1);
		send_vertex(32'h0, 32'h0, 32'h0);
		send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_vertex(32'h0001_0000, 32'h0, 32'h0);
		send_vertex(32'hFFFF_0000, 32'h0, 32'h0);
		send_vertex(32'h0000_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF);
		send_vertex(32'hFFFF_0001, 32'hFFFF_0001, 32'h0000_0001);
		send_vertex(32'h0, 32'h0001_0000, 32'h0);
		send_vertex(32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000);
		drain();

		// Large scale factor overflows the quotient; resolution past range saturates.
		cfg_write(CFG_ROW0, 64'h0000_0000_0000_7FFF);
		cfg_write(CFG_ROW1, 64'h0000_0000_8000_0000);
		cfg_write(CFG_ROW3, 64'h0001_0000_0000_0000);
		cfg_write(CFG_WIDTH, 64'd8191);
		cfg_write(CFG_HEIGHT, 64'd0);
		send_vertex(32'h0000_0100, 32'h0000_0100, 32'h0);
		send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000);
		send_vertex(32'h0000_0001, 32'hFFFF_FFFF, 32'h0);
		send_vertex(32'h0, 32'h0, 32'h7FFF_FFFF);
		drain();

		// Zero w with signed numerators; unused register indexes are written too.
		cfg_write(CFG_ROW0, rand_row());
		cfg_write(CFG_ROW1, rand_row());
		cfg_write(CFG_ROW2, rand_row());
		cfg_write(CFG_ROW3, 64'h0);
		cfg_write(CFG_SPARE_LO, {$urandom(), $urandom()});
		cfg_write(CFG_SPARE_HI, {$urandom(), $urandom()});
		send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0);
		send_vertex($urandom(), $urandom(), $urandom());
		send_vertex($urandom(), $urandom(), $urandom());
		drain();

		// Random phases with fresh matrices, resolutions and pacing.
		for (int ph = 0; ph < 10; ph++) begin
			calm = (ph % 3 == 2);
			cfg_write(CFG_ROW0, (ph % 4 == 0) ? IDENT_ROW0 | rand_row() & 64'h00FF : rand_row());
			cfg_write(CFG_ROW1, (ph % 4 == 0) ? IDENT_ROW1 : rand_row());
			cfg_write(CFG_ROW2, (ph == 5) ? {$urandom(), $urandom()} : rand_row());
			case (ph % 4)
				0: w_row = IDENT_ROW3;
				1: w_row = {16'($urandom_range(16'h0100, 16'h4000)), rand_coef(), 32'h0};
				2: w_row = rand_row();
				default: w_row = {$urandom(), $urandom()};
			endcase
			cfg_write(CFG_ROW3, w_row);
			cfg_write(CFG_WIDTH, rand_res());
			cfg_write(CFG_HEIGHT, rand_res());
			if (ph == 3) begin
				calm = 1'b1;
				hold_req = 1'b1;
			end
			for (int i = 0; i < 60; i++)
				send_vertex(rand_coord(), rand_coord(), rand_coord());
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
